@@ hw/rtl/spq_pkg.sv @@
// Package for the stable sorted priority queue.
// Holds sizes, request and status codes, and the entry and control types.
// No dependencies.
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);

	typedef enum logic [1:0] {
		REQ_ENQ   = 2'd0,
		REQ_DEQ   = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0]        value;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// per-transaction shift command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry, compares it with the
// incoming priority and shifts toward either neighbor. Uses spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               prev_ge,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output logic               ge,
	output spq_pkg::entry_t    entry
);
	import spq_pkg::*;

	entry_t entry_q;

	// ge is a prefix over the chain since entries stay sorted
	assign ge    = occupied && (entry_q.prio >= new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!ge) begin
				if (prev_ge) begin
					entry_q <= new_entry;
				end else begin
					entry_q <= prev_entry;
				end
			end
		end else if (ctrl.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ hw/rtl/stable_priority_queue_core.sv @@
// Stable sorted priority queue of spq_pkg::DEPTH entries built as a chain of
// compare-and-shift cells; equal priorities leave in arrival order. Each
// request first updates the cell chain and the count; then the result
// (front, rear, count, status) is registered. No new request is taken
// while one is pending, and a result waiting on out_stall holds off the
// next request. Uses spq_pkg and spq_cell.
module stable_priority_queue_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [spq_pkg::DATA_W-1:0]        data_value,
	input  logic signed [spq_pkg::PRIO_W-1:0] prio,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [spq_pkg::DATA_W-1:0]        head_value,
	output logic signed [spq_pkg::PRIO_W-1:0] head_prio,
	output logic [spq_pkg::DATA_W-1:0]        tail_value,
	output logic [spq_pkg::CNT_W-1:0]         occupancy,
	output logic                              is_empty
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             pend_q;
	status_t          status_q;
	logic             out_valid_q;
	logic [1:0]       status_out_q;
	entry_t           head_q;
	logic [DATA_W-1:0] tail_q;
	logic [CNT_W-1:0] occ_q;

	logic             accept;
	logic             load_out;
	logic             full;
	logic             empty;
	cell_ctrl_t       ctrl;
	status_t          status_nxt;
	logic [CNT_W-1:0] count_nxt;
	entry_t           new_entry;
	entry_t           zero_entry;
	entry_t           cells [DEPTH];
	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] occ;
	entry_t           tail_entry;
	logic [CNT_W-1:0] tail_idx_w;

	assign in_stall  = pend_q || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign load_out  = pend_q && (!out_valid_q || !out_stall);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign new_entry = '{value: data_value, prio: prio};
	assign zero_entry = '0;

	always_comb begin
		ctrl       = '0;
		status_nxt = ST_OK;
		count_nxt  = count_q;
		unique case (req_type)
			REQ_ENQ: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctrl.ins  = accept;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_DEQ: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					ctrl.rem  = accept;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			REQ_CLEAR: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			assign occ[g] = (count_q > CNT_W'(g));
			spq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occupied  (occ[g]),
				.prev_ge   ((g == 0) ? 1'b1 : ge[(g == 0) ? 0 : g - 1]),
				.new_entry (new_entry),
				.prev_entry(cells[(g == 0) ? 0 : g - 1]),
				.next_entry((g == DEPTH - 1) ? zero_entry : cells[(g == DEPTH - 1) ? g : g + 1]),
				.ge        (ge[g]),
				.entry     (cells[g])
			);
		end
	endgenerate

	assign tail_idx_w = count_q - CNT_W'(1);
	assign tail_entry = cells[tail_idx_w[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
				pend_q  <= 1'b1;
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
		end
		if (load_out) begin
			status_out_q <= status_q;
			occ_q        <= count_q;
			head_q       <= empty ? zero_entry : cells[0];
			tail_q       <= empty ? '0 : tail_entry.value;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_out_q;
	assign head_value = head_q.value;
	assign head_prio  = head_q.prio;
	assign tail_value = tail_q;
	assign occupancy  = occ_q;
	assign is_empty   = (occ_q == '0);

endmodule

@@ hw/rtl/spq_checker.sv @@
// Port-level checks for stable_priority_queue_core, attached by bind.
// Uses spq_pkg.
module spq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [1:0]                        status,
	input logic [spq_pkg::DATA_W-1:0]        head_value,
	input logic signed [spq_pkg::PRIO_W-1:0] head_prio,
	input logic [spq_pkg::DATA_W-1:0]        tail_value,
	input logic [spq_pkg::CNT_W-1:0]         occupancy,
	input logic                              is_empty
);
	import spq_pkg::*;

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (occupancy == '0)))
		else $error("is_empty disagrees with occupancy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (head_value == '0 && head_prio == '0 && tail_value == '0))
		else $error("empty queue shows nonzero entry");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CNT_W'(DEPTH)))
		else $error("occupancy above depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)))
		else $error("full status without full queue");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.head_value(head_value),
	.head_prio (head_prio),
	.tail_value(tail_value),
	.occupancy (occupancy),
	.is_empty  (is_empty)
);

@@ test/stable_priority_queue_core_test.sv @@
// Self-checking testbench for stable_priority_queue_core: random bursts of requests
// against a sorted shadow queue, results checked field by field in arrival order.
// Depends on spq_pkg and the stable_priority_queue_core RTL.
module stable_priority_queue_core_test;
	import spq_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 400;

	typedef struct {
		logic [1:0]               req;
		logic [DATA_W-1:0]        value;
		logic signed [PRIO_W-1:0] level;
	} request_t;

	typedef struct {
		logic [1:0]               status;
		logic [DATA_W-1:0]        head_value;
		logic signed [PRIO_W-1:0] head_prio;
		logic [DATA_W-1:0]        tail_value;
		logic [CNT_W-1:0]         occupancy;
		logic                     is_empty;
	} report_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} traffic_t;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                req_type = REQ_ENQ;
	logic [DATA_W-1:0]         data_value = '0;
	logic signed [PRIO_W-1:0]  prio = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                status;
	logic [DATA_W-1:0]         head_value;
	logic signed [PRIO_W-1:0]  head_prio;
	logic [DATA_W-1:0]         tail_value;
	logic [CNT_W-1:0]          occupancy;
	logic                      is_empty;

	request_t pending_requests[$];
	report_t  expected_reports[$];
	request_t next_req;
	report_t  want;

	// shadow of the sorted store, front at index 0
	logic [DATA_W-1:0]        shadow_value[DEPTH];
	logic signed [PRIO_W-1:0] shadow_prio[DEPTH];
	int                       shadow_count = 0;

	int          fail_count = 0;
	bit          in_busy = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          stall_phase = 0;
	stall_mode_t stall_mode = STALL_NONE;

	stable_priority_queue_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.data_value (data_value),
		.prio       (prio),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.head_value (head_value),
		.head_prio  (head_prio),
		.tail_value (tail_value),
		.occupancy  (occupancy),
		.is_empty   (is_empty)
	);

	always #5 clk = ~clk;

	function automatic report_t apply_request(input request_t r);
		report_t res;
		int pos;
		int k;
		res.status = ST_OK;
		case (r.req)
		REQ_ENQ: begin
			if (shadow_count == DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// new entry goes behind every entry of greater or equal priority
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] >= r.level)
					pos++;
				for (k = shadow_count; k > pos; k--) begin
					shadow_value[k] = shadow_value[k-1];
					shadow_prio[k] = shadow_prio[k-1];
				end
				shadow_value[pos] = r.value;
				shadow_prio[pos] = r.level;
				shadow_count++;
			end
		end
		REQ_DEQ: begin
			if (shadow_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				for (k = 0; k + 1 < shadow_count; k++) begin
					shadow_value[k] = shadow_value[k+1];
					shadow_prio[k] = shadow_prio[k+1];
				end
				shadow_count--;
			end
		end
		REQ_CLEAR: begin
			if (shadow_count == 0)
				res.status = ST_EMPTY;
			shadow_count = 0;
		end
		default: ;
		endcase
		if (shadow_count == 0) begin
			res.head_value = '0;
			res.head_prio = '0;
			res.tail_value = '0;
		end else begin
			res.head_value = shadow_value[0];
			res.head_prio = shadow_prio[0];
			res.tail_value = shadow_value[shadow_count-1];
		end
		res.occupancy = shadow_count[CNT_W-1:0];
		res.is_empty = (shadow_count == 0);
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] expected,
			input logic [DATA_W-1:0] actual);
		if (actual !== expected) begin
			$error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
			fail_count++;
		end
	endfunction

	function automatic void add_request(input logic [1:0] req, input logic [DATA_W-1:0] value,
			input logic signed [PRIO_W-1:0] level);
		request_t r;
		r.req = req;
		r.value = value;
		r.level = level;
		pending_requests.push_back(r);
	endfunction

	// wide random or a narrow band to force ties, equally often; sometimes the corners
	function automatic logic signed [PRIO_W-1:0] pick_prio();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return PRIO_W'($urandom());
		if (roll < 8)
			return PRIO_W'(int'($urandom_range(0, 4)) - 2);
		case ($urandom_range(0, 3))
		0: return 16'sh8000;
		1: return 16'sh7fff;
		2: return 16'sh0000;
		default: return 16'shffff;
		endcase
	endfunction

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (arst_n && !in_busy) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
				req_type <= 2'($urandom_range(0, 3));
				data_value <= $urandom();
			end else if (pending_requests.size() > 0) begin
				next_req = pending_requests.pop_front();
				in_valid <= 1'b1;
				req_type <= next_req.req;
				data_value <= next_req.value;
				prio <= next_req.level;
				in_busy = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: drives out_stall with a stall pattern chosen at random
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 64 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
		STALL_NONE:    out_stall <= 1'b0;
		STALL_LIGHT:   out_stall <= ($urandom_range(0, 2) == 0);
		STALL_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
		default:       out_stall <= (stall_phase % 3 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction with nothing expected: status %0d occupancy %0d",
						status, occupancy);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("head_value", want.head_value, head_value);
					check_field("head_prio", DATA_W'(want.head_prio), DATA_W'(head_prio));
					check_field("tail_value", want.tail_value, tail_value);
					check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(occupancy));
					check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty));
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				next_req.req = req_type;
				next_req.value = data_value;
				next_req.level = prio;
				expected_reports.push_back(apply_request(next_req));
				in_busy = 1'b0;
			end
		end
	end

	initial begin
		int roll;
		int len;
		int i;
		int random_items;
		int enq_pct;
		int deq_pct;
		int clr_pct;
		traffic_t mix;
		logic [1:0] req;

		// empty-queue corner cases, priority extremes, ties at the top
		add_request(REQ_DEQ, 32'h1234_5678, 16'sh0001);
		add_request(REQ_CLEAR, 32'h0, 16'sh0);
		add_request(REQ_UNUSED, 32'hdead_beef, 16'sh7fff);
		add_request(REQ_ENQ, 32'hffff_ffff, 16'sh7fff);
		add_request(REQ_ENQ, 32'h0000_0000, 16'sh8000);
		add_request(REQ_ENQ, 32'h0000_0001, 16'sh7fff);
		add_request(REQ_DEQ, 32'h0, 16'sh0);
		add_request(REQ_CLEAR, 32'h0, 16'sh0);
		// fill to capacity with clustered priorities, then overflow once
		for (i = 0; i < DEPTH + 1; i++)
			add_request(REQ_ENQ, 32'h100 + i, PRIO_W'((i % 3) - 1));
		add_request(REQ_DEQ, 32'h0, 16'sh0);

		random_items = 0;
		while (random_items < RANDOM_REQUESTS) begin
			roll = $urandom_range(0, 9);
			mix = (roll < 4) ? MIX_FILL : (roll < 7) ? MIX_DRAIN :
				(roll < 9) ? MIX_BALANCED : MIX_NOISE;
			len = $urandom_range(8, 40);
			case (mix)
			MIX_FILL:     begin enq_pct = 85; deq_pct = 12; clr_pct = 1;  end
			MIX_DRAIN:    begin enq_pct = 17; deq_pct = 80; clr_pct = 1;  end
			MIX_BALANCED: begin enq_pct = 50; deq_pct = 45; clr_pct = 3;  end
			default:      begin enq_pct = 40; deq_pct = 30; clr_pct = 15; end
			endcase
			repeat (len) begin
				roll = $urandom_range(0, 99);
				if (roll < enq_pct)
					req = REQ_ENQ;
				else if (roll < enq_pct + deq_pct)
					req = REQ_DEQ;
				else if (roll < enq_pct + deq_pct + clr_pct)
					req = REQ_CLEAR;
				else
					req = REQ_UNUSED;
				add_request(req, $urandom(), pick_prio());
				if (req != REQ_UNUSED)
					random_items++;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_requests.size() > 0 || in_busy || expected_reports.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("stable_priority_queue_core_test: PASS");
		else
			$display("stable_priority_queue_core_test: FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("stable_priority_queue_core_test: FAIL");
		$finish;
	end

endmodule
